// ----- rtl/core/ff_pkg.sv -----
package ff_pkg;

  // Delay line and sine table sizes; both are powers of two.
  localparam int DELAY_SIZE      = 1024;
  localparam int SINE_TABLE_SIZE = 256;
  localparam int DL_AW           = $clog2(DELAY_SIZE);
  localparam int TBL_AW          = $clog2(SINE_TABLE_SIZE);
  localparam int POS_W           = DL_AW + 8;

  localparam int CFG_W   = 32;
  localparam int DELAY_W = 17;
  localparam int LFO_W   = 17;

  localparam logic [16:0] MIN_DELAY_RST   = 17'd61440;
  localparam logic [16:0] SWEEP_DEPTH_RST = 17'd36864;
  localparam logic [31:0] LFO_STEP_RST    = 32'd19685;

  localparam logic [1:0] REG_MIN_DELAY   = 2'd0;
  localparam logic [1:0] REG_SWEEP_DEPTH = 2'd1;
  localparam logic [1:0] REG_LFO_STEP    = 2'd2;

  localparam logic [17:0] GAIN_OUT_Q15 = 18'd9830;
  localparam logic [17:0] GAIN_FB_Q15  = 18'd13763;

  // Shared multiplier operand selection.
  localparam logic [2:0] MUL_DEPTH = 3'd0;
  localparam logic [2:0] MUL_LEFT  = 3'd1;
  localparam logic [2:0] MUL_RIGHT = 3'd2;
  localparam logic [2:0] MUL_OUT   = 3'd3;
  localparam logic [2:0] MUL_FB    = 3'd4;

  typedef struct packed {
    logic       take_in;
    logic [2:0] mul_sel;
    logic       ld_acc;
    logic       ld_pos;
    logic       rd_left;
    logic       rd_right;
    logic       ld_d8;
    logic       ld_y;
    logic       commit;
  } ff_cmd_t;

  typedef logic [LFO_W-1:0] lfo_table_t [SINE_TABLE_SIZE];

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

  // sin(x) in Q30 on the first quadrant, Taylor series through x^9.
  function automatic logic signed [63:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    return sum;
  endfunction

  // Table of (sin+1)/2 in unsigned Q1.16, built at elaboration.
  function automatic lfo_table_t build_lfo_table();
    lfo_table_t tbl;
    logic [63:0] a;
    logic [63:0] e;
    logic signed [63:0] s;
    logic neg;
    for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
      a   = (64'(i) * TWO_PI_Q30) / SINE_TABLE_SIZE;
      neg = 1'b0;
      if (a >= PI_Q30) begin
        a   = a - PI_Q30;
        neg = 1'b1;
      end
      if (a > HALF_PI_Q30) a = PI_Q30 - a;
      s = quarter_sine(a);
      if (s > $signed(ONE_Q30)) s = $signed(ONE_Q30);
      if (s < 0) s = 0;
      if (neg) s = -s;
      e = ($unsigned($signed(ONE_Q30) + s)) >> 15;
      tbl[i] = e[LFO_W-1:0];
    end
    return tbl;
  endfunction

  localparam lfo_table_t LFO_TABLE = build_lfo_table();

endpackage

// ----- rtl/core/feedback_flanger.sv -----
// Feedback flanger: one signed Q1.15 sample in, one flanged sample out.
//
// Input channel: sample_in with in_valid / in_ready. Output channel:
// sample_out with out_valid / out_ready. An item moves on a clock edge
// where valid and ready are both high.
// Configuration: cfg_en, cfg_index and cfg_data write the minimum delay (0),
// the sweep depth (1) or the LFO step (2); other indexes are ignored.
// Write only while no item is in flight.
//
// Each item runs through a nine-step sequence around one shared 26x18
// multiplier and a single-port delay-line RAM: LFO lookup, depth multiply,
// read position, two RAM reads (left and right tap), interpolation, the
// two gain products, then commit. A new item is taken only once the last
// one has committed, as the multiplier is shared across its five products
// and the RAM takes the two reads in turn.
// A finished item waits in the output register; if the receiver stalls,
// the next item is still taken and its commit holds until the register
// frees. Reset (rst, synchronous) restores register defaults, zeroes the
// LFO phase and write pointer, and marks the whole delay line as empty so
// that unwritten entries read as zero; no clearing pass is needed.
module feedback_flanger import ff_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  input  logic               cfg_en,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  ff_cmd_t cmd;

  // sequencer: owns the handshakes and steps the datapath
  ff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: config registers, LFO, delay RAM, multiplier, output register
  ff_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .sample_out (sample_out)
  );

  // Commit must never overwrite an item still waiting at the output.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit over a pending output item");

  // One item at a time: acceptance drops ready for the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // Sequence steps that touch RAM or the item boundary never overlap.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take_in, cmd.ld_pos, cmd.rd_left, cmd.rd_right, cmd.ld_d8,
              cmd.commit}))
    else $error("overlapping sequencer steps");

  // A new output item appears only after a commit.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("output valid without commit");

endmodule

// ----- rtl/core/ff_ctrl.sv -----
module ff_ctrl import ff_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output ff_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEPTH  = 4'd1;
  localparam logic [3:0] S_POS    = 4'd2;
  localparam logic [3:0] S_RD_L   = 4'd3;
  localparam logic [3:0] S_RD_R   = 4'd4;
  localparam logic [3:0] S_MAC    = 4'd5;
  localparam logic [3:0] S_M_OUT  = 4'd6;
  localparam logic [3:0] S_M_FB   = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.take_in = in_valid;
        if (in_valid) state_next = S_DEPTH;
      end
      S_DEPTH: begin
        cmd.mul_sel = MUL_DEPTH;
        cmd.ld_acc  = 1'b1;
        state_next  = S_POS;
      end
      S_POS: begin
        cmd.ld_pos = 1'b1;
        state_next = S_RD_L;
      end
      S_RD_L: begin
        cmd.rd_left = 1'b1;
        state_next  = S_RD_R;
      end
      S_RD_R: begin
        cmd.rd_right = 1'b1;
        cmd.mul_sel  = MUL_LEFT;
        cmd.ld_acc   = 1'b1;
        state_next   = S_MAC;
      end
      S_MAC: begin
        cmd.mul_sel = MUL_RIGHT;
        cmd.ld_d8   = 1'b1;
        state_next  = S_M_OUT;
      end
      S_M_OUT: begin
        cmd.mul_sel = MUL_OUT;
        cmd.ld_acc  = 1'b1;
        state_next  = S_M_FB;
      end
      S_M_FB: begin
        cmd.mul_sel = MUL_FB;
        cmd.ld_acc  = 1'b1;
        cmd.ld_y    = 1'b1;
        state_next  = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register is free
        cmd.commit = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/ff_datapath.sv -----
module ff_datapath import ff_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ff_cmd_t            cmd,
  input  logic               cfg_en,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic signed [15:0] sample_in,
  output logic signed [15:0] sample_out
);

  logic [DELAY_W-1:0] min_delay;
  logic [DELAY_W-1:0] sweep_depth;
  logic [31:0]        lfo_step;

  logic [DL_AW-1:0]   wp;
  logic               full;
  logic [31:0]        lfo_phase;

  logic signed [15:0] x;
  logic [LFO_W-1:0]   lfo;
  logic signed [43:0] acc;
  logic [POS_W-1:0]   rd_pos;
  logic signed [15:0] mem_q;
  logic               mem_ok;
  logic signed [24:0] d8;
  logic signed [15:0] y;

  logic signed [15:0] mem [DELAY_SIZE];

  logic [DL_AW-1:0]   left;
  logic [DL_AW-1:0]   right;
  logic [DL_AW-1:0]   rd_addr;
  logic [7:0]         frac;
  logic [8:0]         inv_frac;
  logic signed [15:0] tap;
  logic [17:0]        delay_sum;
  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [43:0] prod;
  logic signed [43:0] mac;
  logic signed [43:0] rnd_full;
  logic signed [21:0] mix;
  logic signed [15:0] mix_sat;

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) return 16'sh7fff;
    if (v < -22'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

  assign left     = rd_pos[POS_W-1:8];
  assign right    = left + 1'b1;
  assign frac     = rd_pos[7:0];
  assign inv_frac = 9'd256 - {1'b0, frac};
  assign rd_addr  = cmd.rd_right ? right : left;
  // never-written entries read as zero
  assign tap      = mem_ok ? mem_q : 16'sd0;

  assign delay_sum = {1'b0, min_delay} + acc[33:16];

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DEPTH: begin
        mul_a = {9'b0, sweep_depth};
        mul_b = {1'b0, lfo};
      end
      MUL_LEFT: begin
        mul_a = {{10{tap[15]}}, tap};
        mul_b = {9'b0, inv_frac};
      end
      MUL_RIGHT: begin
        mul_a = {{10{tap[15]}}, tap};
        mul_b = {10'b0, frac};
      end
      MUL_OUT: begin
        mul_a = {d8[24], d8};
        mul_b = GAIN_OUT_Q15;
      end
      MUL_FB: begin
        mul_a = {d8[24], d8};
        mul_b = GAIN_FB_Q15;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign mac  = acc + prod;

  // round to nearest, halves up, after dropping 23 bits
  assign rnd_full = (acc + 44'sd4194304) >>> 23;
  assign mix      = {{6{x[15]}}, x} + rnd_full[21:0];
  assign mix_sat  = sat16(mix);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay   <= MIN_DELAY_RST;
      sweep_depth <= SWEEP_DEPTH_RST;
      lfo_step    <= LFO_STEP_RST;
      wp          <= '0;
      full        <= 1'b0;
      lfo_phase   <= '0;
    end else begin
      if (cfg_en) begin
        unique case (cfg_index)
          REG_MIN_DELAY:   min_delay   <= cfg_data[DELAY_W-1:0];
          REG_SWEEP_DEPTH: sweep_depth <= cfg_data[DELAY_W-1:0];
          REG_LFO_STEP:    lfo_step    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        wp        <= wp + 1'b1;
        lfo_phase <= lfo_phase + lfo_step;
        if (wp == DL_AW'(DELAY_SIZE - 1)) full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      x   <= sample_in;
      lfo <= LFO_TABLE[lfo_phase[31 -: TBL_AW]];
    end
    if (cmd.ld_acc) acc <= prod;
    if (cmd.ld_pos) rd_pos <= {wp, 8'b0} - POS_W'(delay_sum);
    if (cmd.ld_d8) d8 <= mac[24:0];
    if (cmd.ld_y) y <= mix_sat;
    if (cmd.commit) sample_out <= y;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_left || cmd.rd_right) begin
      mem_q  <= mem[rd_addr];
      mem_ok <= full || (rd_addr < wp);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) mem[wp] <= mix_sat;
  end

endmodule

// ----- test/feedback_flanger_checker.sv -----
module feedback_flanger_checker import ff_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] sample_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] sample_out,
  input  logic               cfg_en,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 mismatch_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned LINE_Q8  = 64'(DELAY_SIZE) * 256;
  localparam longint unsigned PI_Q30   = 64'd3373259426;
  localparam longint unsigned HALF_PI  = 64'd1686629713;
  localparam longint unsigned TWO_PI   = 64'd6746518852;
  localparam longint          UNIT_Q30 = 64'sd1073741824;
  localparam longint          WET_GAIN = 9830;
  localparam longint          FB_GAIN  = 13763;

  logic [16:0]        sine_lut [SINE_TABLE_SIZE];
  logic signed [15:0] tap_mem  [DELAY_SIZE];
  int unsigned        wr_ptr;
  logic [31:0]        phase_acc;
  logic [16:0]        base_q8;
  logic [16:0]        depth_q8;
  logic [31:0]        phase_step;

  logic signed [15:0] flanged_q [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // Truncated Taylor series of sin on the first quadrant, Q30 in and out.
  function automatic longint quadrant_sin(input longint unsigned x);
    longint unsigned sq;
    longint unsigned term;
    longint          acc;
    sq   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 4; k++) begin
      term = ((term * sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    return acc;
  endfunction

  function automatic void fill_sine_lut();
    longint unsigned ang;
    longint          s;
    logic            neg;
    for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
      ang = (64'(i) * TWO_PI) / SINE_TABLE_SIZE;
      neg = 1'b0;
      if (ang >= PI_Q30) begin
        ang = ang - PI_Q30;
        neg = 1'b1;
      end
      if (ang > HALF_PI) ang = PI_Q30 - ang;
      s = quadrant_sin(ang);
      if (s > UNIT_Q30) s = UNIT_Q30;
      if (s < 0) s = 0;
      if (neg) s = -s;
      sine_lut[i] = 17'((UNIT_Q30 + s) >> 15);
    end
  endfunction

  // Divide by 2^23, rounding to nearest with halves going up.
  function automatic longint round_q23(input longint v);
    return (v + 64'sd4194304) >>> 23;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Advance the flanger by one sample and return the wet output.
  function automatic logic signed [15:0] next_flanged(input logic signed [15:0] x);
    longint unsigned lut_idx;
    longint unsigned dly;
    longint unsigned rd;
    int unsigned     left;
    int unsigned     right;
    int              frac;
    longint          d8;
    longint          wet;
    longint          fb;
    lut_idx = (64'(phase_acc) * SINE_TABLE_SIZE) >> 32;
    dly = 64'(base_q8) + ((64'(depth_q8) * 64'(sine_lut[lut_idx])) >> 16);
    dly = dly % LINE_Q8;
    rd  = 64'(wr_ptr) * 256 + LINE_Q8 - dly;
    if (rd >= LINE_Q8) rd = rd - LINE_Q8;
    left  = int'(rd >> 8);
    frac  = int'(rd % 256);
    right = (left + 1) % DELAY_SIZE;
    d8 = longint'(256 - frac) * longint'(tap_mem[left])
       + longint'(frac) * longint'(tap_mem[right]);
    wet = longint'(x) + round_q23(d8 * WET_GAIN);
    fb  = longint'(x) + round_q23(d8 * FB_GAIN);
    tap_mem[wr_ptr] = clip16(fb);
    wr_ptr    = (wr_ptr + 1) % DELAY_SIZE;
    phase_acc = phase_acc + phase_step;
    return clip16(wet);
  endfunction

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst) begin
      fill_sine_lut();
      foreach (tap_mem[i]) tap_mem[i] = '0;
      wr_ptr     = 0;
      phase_acc  = '0;
      base_q8    = 17'd61440;
      depth_q8   = 17'd36864;
      phase_step = 32'd19685;
      flanged_q.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_MIN_DELAY:   base_q8    = cfg_data[16:0];
          REG_SWEEP_DEPTH: depth_q8   = cfg_data[16:0];
          REG_LFO_STEP:    phase_step = cfg_data[31:0];
          default: ;
        endcase
      end
      // Check the outgoing item before queueing a new one: it cannot belong to it.
      if (out_valid && out_ready) begin
        if (flanged_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected output item %0d at %0t", sample_out, $time);
          mismatch_count++;
        end else begin
          want = flanged_q.pop_front();
          if (sample_out !== want) begin
            if (mismatch_count < 10)
              $display("sample_out mismatch at %0t: expected %0d, got %0d",
                       $time, want, sample_out);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) flanged_q.push_back(next_flanged(sample_in));
    end
    pending_count = flanged_q.size();
  end

endmodule

// ----- test/feedback_flanger_tb.sv -----
module feedback_flanger_tb import ff_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; the block must ignore writes to it.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int SEG_ITEMS   = 250;
  localparam int SEGMENTS    = 8;
  localparam int SETTLE      = 20;      // cycles past the last result before a write
  localparam int CYCLE_LIMIT = 500000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] sample_in;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] sample_out;
  logic               cfg_en;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  int mismatch_count;
  int pending_count;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;

  always #1 clk = ~clk;

  feedback_flanger dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  feedback_flanger_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_in      (sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample_out     (sample_out),
    .cfg_en         (cfg_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Stall the receiver at random; redraw ready on every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard stop in case the block hangs or loses an item.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Write one register; entered and left at a falling edge.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_config(input logic [16:0] base, input logic [16:0] depth,
                             input logic [31:0] step);
    write_reg(REG_MIN_DELAY, CFG_W'(base));
    write_reg(REG_SWEEP_DEPTH, CFG_W'(depth));
    write_reg(REG_LFO_STEP, step);
  endtask

  // Offer one item and hold it until taken. Leave valid high on return so that
  // a back-to-back item needs no second assignment in the same step.
  task automatic push_sample(input logic signed [15:0] s);
    in_valid  <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid for a random number of cycles, or not at all.
  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Hold off until every queued item has come out, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mostly full-range noise; a share of full-scale values to drive saturation.
  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic set_idle_phase(input int ph);
    case (ph)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 86; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 86; end
      default: begin idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample_in = '0;
    out_ready = 1'b0;
    cfg_en    = 1'b0;
    cfg_index = REG_MIN_DELAY;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes at the reset settings; the line is still empty.
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    push_sample(-16'sd1);
    push_sample(16'sh5555);
    push_sample(16'shaaaa);
    drain();

    // One-sample delay with a frozen LFO: full-scale input must saturate both
    // the output and the stored feedback, in both directions.
    load_config(17'd256, 17'd0, 32'd0);
    repeat (3) push_sample(16'sh7fff);
    repeat (3) push_sample(16'sh8000);
    drain();

    // Zero delay: the tap reads the entry about to be overwritten.
    write_reg(REG_MIN_DELAY, CFG_W'(0));
    push_sample(16'sd12345);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    drain();

    // Write to an unused index (must be ignored), then a one-and-a-half-sample base
    // with the deepest sweep and a quarter-cycle LFO step.
    write_reg(REG_UNUSED, CFG_W'($urandom));
    load_config(17'd384, 17'd130816, 32'h4000_0000);
    repeat (5) push_sample(rand_sample());
    drain();

    // Random segments: each gets its own settings and one of four idling phases,
    // and pauses halfway and at its end until every result is back.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: load_config(17'd61440, 17'd36864, 32'd19685);
        1: load_config(17'd0, 17'd130816, 32'hffff_ffff);
        2: load_config(17'd130816, 17'd130816, $urandom);
        3: load_config(17'($urandom_range(2048)), 17'($urandom_range(4096)),
                       32'($urandom_range(32'h0400_0000)));
        4: load_config(17'd0, 17'd0, 32'd0);
        default: load_config(17'($urandom_range(130816)), 17'($urandom_range(130816)),
                             $urandom);
      endcase
      set_idle_phase(seg % 4);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        push_sample(rand_sample());
        if (n == SEG_ITEMS / 2 || n == SEG_ITEMS - 1) drain();
        else sender_gap();
      end
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- feedback_flanger.f -----
rtl/core/ff_pkg.sv
rtl/core/ff_ctrl.sv
rtl/core/ff_datapath.sv
rtl/core/feedback_flanger.sv
test/feedback_flanger_checker.sv
test/feedback_flanger_tb.sv
